// ===== rtl/mrbq_pkg.sv =====
// Shared types and codes for the multi-reader broadcast queue.
package mrbq_pkg;

  typedef enum logic [2:0] {
    OP_ENQ   = 3'd0,
    OP_REG   = 3'd1,
    OP_UNREG = 3'd2,
    OP_DEQ   = 3'd3,
    OP_REL   = 3'd4,
    OP_FLUSH = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_INVALID = 3'd1,
    STAT_EMPTY   = 3'd2,
    STAT_END     = 3'd3,
    STAT_HOLD    = 3'd4,
    STAT_FULL    = 3'd5,
    STAT_NOSLOT  = 3'd6
  } stat_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REL_WR,
    S_WALK_RD,
    S_WALK_WR,
    S_RET_RD,
    S_RET_CK,
    S_DONE
  } state_e;

  localparam int unsigned DataW  = 32;
  localparam int unsigned TotalW = 38;
  localparam int unsigned LenW   = 7;

endpackage

// ===== rtl/multi_reader_broadcast_queue_top.sv =====
// Broadcast FIFO with per-reader pointers, entries and owed counts held in memories.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------
//  in      | in_valid_i / in_stall_o | opcode, reader_id, buffer handle/bytes/stamp
//  out     | out_valid_o/ out_stall_i| status, dropped, slot, entry, length, totals
//
// Enqueue, dequeue, flush and every error case go from idle straight to the result.
// Register walks the live entries to raise their owed counts; unregister walks the
// entries still owed by the reader to lower them; release lowers the owed count of the
// reader's entry; both then retire head entries for as long as their owed count is zero.
// The walks are paced by the single read/write port pair of the owed-count memory.
// Reset leaves the queue empty and all readers free; no clearing pass is needed.
// A stalled result holds in the output register; the next request waits for it.
module multi_reader_broadcast_queue_top #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned MAX_READERS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    opcode_i,
  input  logic [2:0]                    reader_id_i,
  input  logic [mrbq_pkg::DataW-1:0]    buffer_handle_i,
  input  logic [mrbq_pkg::DataW-1:0]    buffer_bytes_i,
  input  logic [mrbq_pkg::DataW-1:0]    stamp_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    status_o,
  output logic                          dropped_o,
  output logic [2:0]                    assigned_reader_o,
  output logic [mrbq_pkg::DataW-1:0]    out_handle_o,
  output logic [mrbq_pkg::DataW-1:0]    out_bytes_o,
  output logic [mrbq_pkg::DataW-1:0]    out_stamp_o,
  output logic [mrbq_pkg::LenW-1:0]     queue_len_o,
  output logic [mrbq_pkg::DataW-1:0]    last_stamp_o,
  output logic [mrbq_pkg::DataW-1:0]    last_bytes_o,
  output logic [mrbq_pkg::TotalW-1:0]   stored_bytes_o
);
  import mrbq_pkg::*;

  localparam int unsigned IW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OW  = $clog2(MAX_READERS + 1);
  localparam int unsigned RIW = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
  localparam int unsigned EW  = 3 * DataW;

  function automatic logic [IW-1:0] wrap_next(input logic [IW-1:0] i);
    wrap_next = (i == IW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // memories
  logic [EW-1:0] entry_mem [QUEUE_DEPTH];
  logic [OW-1:0] owed_mem  [QUEUE_DEPTH];
  logic          ent_we, ent_re, owd_we, owd_re;
  logic [IW-1:0] ent_waddr, ent_raddr, owd_waddr, owd_raddr;
  logic [EW-1:0] ent_wdata, ent_rdata_q;
  logic [OW-1:0] owd_wdata, owd_rdata_q;

  always_ff @(posedge clk_i) begin
    if (ent_we) entry_mem[ent_waddr] <= ent_wdata;
    if (ent_re) ent_rdata_q <= entry_mem[ent_raddr];
    if (owd_we) owed_mem[owd_waddr] <= owd_wdata;
    if (owd_re) owd_rdata_q <= owed_mem[owd_raddr];
  end

  // state
  state_e state_q, state_d;
  logic [IW-1:0] head_q, tail_q, walk_addr_q, rel_addr_q;
  logic [CW-1:0] live_q, walk_cnt_q;
  logic [OW-1:0] act_cnt_q;
  logic          walk_inc_q, deq_ok_q, dropped_q;
  stat_e         stat_q;
  logic [2:0]    assigned_q;
  logic [MAX_READERS-1:0] r_active_q, r_end_q, r_hold_q;
  logic [IW-1:0] r_pos_q [MAX_READERS];
  logic [DataW-1:0]  last_stamp_q, last_bytes_q;
  logic [TotalW-1:0] total_q;
  logic out_valid_q;
  logic [2:0] o_status_q, o_assigned_q;
  logic o_dropped_q;
  logic [DataW-1:0] o_handle_q, o_bytes_q, o_stamp_q;

  // request decode
  logic          acc, out_free, rid_ok, enq_ok, deq_ok, rel_ok, slot_found;
  logic [RIW-1:0] rsel, slot;
  logic [IW-1:0] rpos;
  logic [CW-1:0] roff;
  op_e           op;
  stat_e         req_stat;
  logic          req_dropped;
  logic [2:0]    req_assigned;
  logic [IW-1:0] req_walk_addr;
  logic [CW-1:0] req_walk_cnt;

  assign op       = op_e'(opcode_i);
  assign acc      = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign rsel     = RIW'(reader_id_i);
  assign rid_ok   = (32'(reader_id_i) < MAX_READERS) && r_active_q[rsel];
  assign rpos     = r_pos_q[rsel];
  assign roff     = CW'(rpos) + ((rpos < head_q) ? CW'(QUEUE_DEPTH) : '0) - CW'(head_q);
  assign enq_ok   = (op == OP_ENQ) && (act_cnt_q != '0) && (live_q != CW'(QUEUE_DEPTH));
  assign deq_ok   = (op == OP_DEQ) && rid_ok && (live_q != '0) && !r_end_q[rsel]
                    && !r_hold_q[rsel];
  assign rel_ok   = (op == OP_REL) && rid_ok && r_hold_q[rsel] && !r_end_q[rsel]
                    && (live_q != '0);

  always_comb begin
    slot       = '0;
    slot_found = 1'b0;
    for (int r = MAX_READERS - 1; r >= 0; r--) begin
      if (!r_active_q[r]) begin
        slot       = RIW'(r);
        slot_found = 1'b1;
      end
    end
  end

  // result fields and walk setup of the incoming request
  always_comb begin
    req_stat      = STAT_OK;
    req_dropped   = 1'b0;
    req_assigned  = '0;
    req_walk_addr = head_q;
    req_walk_cnt  = live_q;
    case (op)
      OP_ENQ: begin
        if (act_cnt_q == '0) req_dropped = 1'b1;
        else if (!enq_ok) req_stat = STAT_FULL;
      end
      OP_REG: begin
        if (!slot_found) req_stat = STAT_NOSLOT;
        else req_assigned = 3'(slot);
      end
      OP_UNREG: begin
        if (!rid_ok) req_stat = STAT_INVALID;
        req_walk_addr = rpos;
        req_walk_cnt  = r_end_q[rsel] ? '0 : live_q - roff;
      end
      OP_DEQ: begin
        if (!rid_ok) req_stat = STAT_INVALID;
        else if (live_q == '0) req_stat = STAT_EMPTY;
        else if (r_end_q[rsel]) req_stat = STAT_END;
        else if (r_hold_q[rsel]) req_stat = STAT_HOLD;
      end
      OP_REL, OP_FLUSH: if (!rid_ok) req_stat = STAT_INVALID;
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          state_d = S_DONE;
          if (op == OP_REG && slot_found) state_d = S_WALK_RD;
          if (op == OP_UNREG && rid_ok) state_d = S_WALK_RD;
          if (rel_ok) state_d = S_REL_WR;
        end
      end
      S_REL_WR:  state_d = S_RET_RD;
      S_WALK_RD: begin
        if (walk_cnt_q != '0) state_d = S_WALK_WR;
        else state_d = walk_inc_q ? S_DONE : S_RET_RD;
      end
      S_WALK_WR: state_d = S_WALK_RD;
      S_RET_RD:  state_d = (live_q != '0) ? S_RET_CK : S_DONE;
      S_RET_CK:  state_d = (owd_rdata_q == '0) ? S_RET_RD : S_DONE;
      S_DONE:    if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    ent_we     = 1'b0;
    ent_waddr  = tail_q;
    ent_wdata  = {buffer_handle_i, buffer_bytes_i, stamp_in_i};
    ent_re     = 1'b0;
    ent_raddr  = head_q;
    owd_we     = 1'b0;
    owd_waddr  = tail_q;
    owd_wdata  = act_cnt_q;
    owd_re     = 1'b0;
    owd_raddr  = head_q;
    case (state_q)
      S_IDLE: begin
        if (acc && enq_ok) begin
          ent_we = 1'b1;
          owd_we = 1'b1;
        end
        if (acc && deq_ok) begin
          ent_re    = 1'b1;
          ent_raddr = rpos;
        end
        if (acc && rel_ok) begin
          owd_re    = 1'b1;
          owd_raddr = rpos;
        end
      end
      S_REL_WR: begin
        owd_we    = 1'b1;
        owd_waddr = rel_addr_q;
        owd_wdata = (owd_rdata_q != '0) ? owd_rdata_q - 1'b1 : owd_rdata_q;
      end
      S_WALK_RD: begin
        owd_re    = (walk_cnt_q != '0);
        owd_raddr = walk_addr_q;
      end
      S_WALK_WR: begin
        owd_we    = 1'b1;
        owd_waddr = walk_addr_q;
        if (walk_inc_q) owd_wdata = owd_rdata_q + 1'b1;
        else owd_wdata = (owd_rdata_q != '0) ? owd_rdata_q - 1'b1 : owd_rdata_q;
      end
      S_RET_RD: begin
        owd_re = (live_q != '0);
        ent_re = (live_q != '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      live_q       <= '0;
      act_cnt_q    <= '0;
      r_active_q   <= '0;
      r_end_q      <= '1;
      r_hold_q     <= '0;
      for (int r = 0; r < MAX_READERS; r++) r_pos_q[r] <= '0;
      last_stamp_q <= '0;
      last_bytes_q <= '0;
      total_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= (state_q == S_DONE && out_free) || (out_valid_q && out_stall_i);
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            case (op)
              OP_ENQ: begin
                if (enq_ok) begin
                  for (int r = 0; r < MAX_READERS; r++) begin
                    if (r_active_q[r] && r_end_q[r]) begin
                      r_pos_q[r] <= tail_q;
                      r_end_q[r] <= 1'b0;
                    end
                  end
                  tail_q       <= wrap_next(tail_q);
                  live_q       <= live_q + 1'b1;
                  total_q      <= total_q + TotalW'(buffer_bytes_i);
                  last_stamp_q <= stamp_in_i;
                  last_bytes_q <= buffer_bytes_i;
                end
              end
              OP_REG: begin
                if (slot_found) begin
                  r_active_q[slot] <= 1'b1;
                  r_hold_q[slot]   <= 1'b0;
                  r_pos_q[slot]    <= head_q;
                  r_end_q[slot]    <= (live_q == '0);
                  act_cnt_q        <= act_cnt_q + 1'b1;
                end
              end
              OP_UNREG: begin
                if (rid_ok) begin
                  r_active_q[rsel] <= 1'b0;
                  r_hold_q[rsel]   <= 1'b0;
                  r_end_q[rsel]    <= 1'b1;
                  r_pos_q[rsel]    <= '0;
                  if (act_cnt_q != '0) act_cnt_q <= act_cnt_q - 1'b1;
                end
              end
              OP_DEQ: if (deq_ok) r_hold_q[rsel] <= 1'b1;
              OP_REL: begin
                if (rid_ok) r_hold_q[rsel] <= 1'b0;
                if (rel_ok) begin
                  if (roff + 1'b1 >= live_q) begin
                    r_end_q[rsel] <= 1'b1;
                    r_pos_q[rsel] <= '0;
                  end else begin
                    r_pos_q[rsel] <= wrap_next(rpos);
                  end
                end
              end
              OP_FLUSH: begin
                if (rid_ok) begin
                  head_q   <= '0;
                  tail_q   <= '0;
                  live_q   <= '0;
                  total_q  <= '0;
                  r_end_q  <= '1;
                  r_hold_q <= '0;
                  for (int r = 0; r < MAX_READERS; r++) r_pos_q[r] <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_RET_CK: begin
          if (owd_rdata_q == '0) begin
            total_q <= total_q - TotalW'(ent_rdata_q[DataW +: DataW]);
            head_q  <= wrap_next(head_q);
            live_q  <= live_q - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // request context and result payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          stat_q      <= req_stat;
          dropped_q   <= req_dropped;
          assigned_q  <= req_assigned;
          deq_ok_q    <= deq_ok;
          rel_addr_q  <= rpos;
          walk_inc_q  <= (op == OP_REG);
          walk_addr_q <= req_walk_addr;
          walk_cnt_q  <= req_walk_cnt;
        end
      end
      S_WALK_WR: begin
        walk_addr_q <= wrap_next(walk_addr_q);
        walk_cnt_q  <= walk_cnt_q - 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          o_status_q   <= stat_q;
          o_dropped_q  <= dropped_q;
          o_assigned_q <= assigned_q;
          o_handle_q   <= deq_ok_q ? ent_rdata_q[2*DataW +: DataW] : '0;
          o_bytes_q    <= deq_ok_q ? ent_rdata_q[DataW +: DataW] : '0;
          o_stamp_q    <= deq_ok_q ? ent_rdata_q[0 +: DataW] : '0;
        end
      end
      default: ;
    endcase
  end

  logic [LenW-1:0]   o_len_q;
  logic [DataW-1:0]  o_lstamp_q, o_lbytes_q;
  logic [TotalW-1:0] o_total_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      o_len_q    <= LenW'(live_q);
      o_lstamp_q <= last_stamp_q;
      o_lbytes_q <= last_bytes_q;
      o_total_q  <= total_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = o_status_q;
  assign dropped_o         = o_dropped_q;
  assign assigned_reader_o = o_assigned_q;
  assign out_handle_o      = o_handle_q;
  assign out_bytes_o       = o_bytes_q;
  assign out_stamp_o       = o_stamp_q;
  assign queue_len_o       = o_len_q;
  assign last_stamp_o      = o_lstamp_q;
  assign last_bytes_o      = o_lbytes_q;
  assign stored_bytes_o    = o_total_q;

endmodule

// ===== rtl/mrbq_checker.sv =====
// Port-level checks for the multi-reader broadcast queue, bound to the top level.
module mrbq_checker #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic        dropped_o,
  input logic [31:0] out_handle_o,
  input logic [6:0]  queue_len_o
);
  import mrbq_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped or changed while stalled");

  a_drop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dropped_o |-> status_o == STAT_OK && queue_len_o == '0)
    else $error("dropped enqueue with bad status or nonempty queue");

  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(queue_len_o) <= QUEUE_DEPTH)
    else $error("queue length beyond depth");

  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_FULL |-> 32'(queue_len_o) == QUEUE_DEPTH)
    else $error("full status with free entries");

  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_handle_o != '0 |-> status_o == STAT_OK && !dropped_o)
    else $error("entry data on a failed request");

endmodule

bind multi_reader_broadcast_queue_top mrbq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mrbq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .dropped_o    (dropped_o),
  .out_handle_o (out_handle_o),
  .queue_len_o  (queue_len_o)
);
